FILE: hdl/rfc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame checker.
`timescale 1ns / 1ps

package rfc_pkg;

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    localparam int HDR_POS  = 0;
    localparam int KEY1_POS = 1;
    localparam int KEY2_POS = 2;
    localparam int DATA_POS = 3;

    // Two payload banks: one can be drained while the next frame fills the other.
    localparam int          NUM_BANKS = 2;
    localparam int          FREE_W    = $clog2(NUM_BANKS + 1);
    localparam logic [FREE_W-1:0] FREE_ALL = FREE_W'(NUM_BANKS);

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_HDR = 2'd1,
        ST_CRC = 2'd2
    } status_t;

    // One frame verdict queued from the front end to the output sequencer.
    typedef struct packed {
        logic    err;
        status_t status;
        logic    bank;
    } cmd_t;

    // Reflected CRC-8, one byte per call.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: hdl/rfc_front.sv
// Front end: frame tracking, CRC, header check, key descramble and payload writes.
`timescale 1ns / 1ps

module rfc_front
    import rfc_pkg::*;
#(
    parameter int DATA_BYTES = 8,
    parameter int AW         = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          frame_start,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          cmd_push,
    output cmd_t          cmd_wdata,
    input  logic          cmd_full,
    input  logic          bank_release
);

    localparam int CRC_POS = DATA_POS + DATA_BYTES;
    localparam int PW      = $clog2(CRC_POS + 1);

    logic [7:0]        header_reg;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        key_reg, key_next;
    logic              hm_reg, hm_next;
    logic              bank_reg, bank_next;
    logic [FREE_W-1:0] free_reg, free_next;

    logic          accept;
    logic [PW-1:0] pos_eff;
    logic [PW-1:0] data_idx;
    logic [7:0]    crc_step;
    logic          bad;
    logic          take_bank;

    assign in_stall = cmd_full || (free_reg == '0);
    assign accept   = in_valid && !in_stall;
    assign pos_eff  = frame_start ? PW'(HDR_POS) : pos_reg;
    assign data_idx = pos_eff - PW'(DATA_POS);
    assign crc_step = crc_update((pos_eff == PW'(HDR_POS)) ? 8'h00 : crc_reg, rx_byte);
    assign bad      = !hm_reg || (crc_reg != rx_byte);

    assign mem_wdata = rx_byte ^ key_reg;
    assign mem_waddr = bank_reg ? (AW'(DATA_BYTES) + AW'(data_idx)) : AW'(data_idx);

    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        key_next  = key_reg;
        hm_next   = hm_reg;
        mem_we    = 1'b0;
        cmd_push  = 1'b0;
        cmd_wdata.err    = bad;
        cmd_wdata.status = !hm_reg ? ST_HDR : (bad ? ST_CRC : ST_OK);
        cmd_wdata.bank   = bank_reg;
        take_bank = 1'b0;
        if (accept) begin
            if (pos_eff == PW'(HDR_POS)) begin
                crc_next = crc_step;
                hm_next  = (rx_byte == header_reg);
                key_next = 8'h00;
                pos_next = PW'(KEY1_POS);
            end else if (pos_eff < PW'(CRC_POS)) begin
                crc_next = crc_step;
                if (pos_eff == PW'(KEY1_POS) || pos_eff == PW'(KEY2_POS))
                    key_next = key_reg ^ rx_byte;
                else
                    mem_we = 1'b1;
                pos_next = pos_eff + PW'(1);
            end else begin
                // CRC byte: hand the verdict to the back end, claim the bank on success
                cmd_push  = 1'b1;
                take_bank = !bad;
                pos_next  = PW'(HDR_POS);
                crc_next  = 8'h00;
            end
        end
        bank_next = take_bank ? !bank_reg : bank_reg;
        case ({take_bank, bank_release})
            2'b10:   free_next = free_reg - FREE_W'(1);
            2'b01:   free_next = free_reg + FREE_W'(1);
            default: free_next = free_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_reg <= HEADER_RESET;
            pos_reg    <= '0;
            crc_reg    <= '0;
            key_reg    <= '0;
            hm_reg     <= 1'b0;
            bank_reg   <= 1'b0;
            free_reg   <= FREE_ALL;
        end else begin
            if (cfg_we)
                header_reg <= cfg_wdata;
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            key_reg  <= key_next;
            hm_reg   <= hm_next;
            bank_reg <= bank_next;
            free_reg <= free_next;
        end
    end

endmodule

FILE: hdl/rfc_cmd_fifo.sv
// Two-entry queue of frame verdicts between the front end and the output sequencer.
`timescale 1ns / 1ps

module rfc_cmd_fifo
    import rfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    input  logic pop,
    output cmd_t rdata,
    output logic full,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: hdl/rfc_back.sv
// Back end: payload buffer and the sequencer that drains one result beat per cycle unless stalled.
`timescale 1ns / 1ps

module rfc_back
    import rfc_pkg::*;
#(
    parameter int DATA_BYTES = 8,
    parameter int AW         = 4,
    parameter int IW         = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mem_we,
    input  logic [AW-1:0] mem_waddr,
    input  logic [7:0]    mem_wdata,
    input  cmd_t          cmd_rdata,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output logic          bank_release,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    data_byte,
    output logic [2:0]    byte_index,
    output logic [1:0]    status,
    output logic          last
);

    localparam int DEPTH = NUM_BANKS * DATA_BYTES;

    logic [7:0] mem [DEPTH];

    logic [IW-1:0] cnt_reg;
    logic          s1_valid_reg;
    logic          s1_err_reg;
    status_t       s1_status_reg;
    logic [IW-1:0] s1_idx_reg;
    logic          s1_last_reg;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic [2:0]    out_idx_reg;
    status_t       out_status_reg;
    logic          out_last_reg;

    logic          advance;
    logic          issue;
    logic          final_beat;
    logic [AW-1:0] raddr;

    assign advance    = !out_valid_reg || !out_stall;
    assign issue      = advance && !cmd_empty;
    assign final_beat = (cnt_reg == IW'(DATA_BYTES - 1));
    assign raddr      = cmd_rdata.bank ? (AW'(DATA_BYTES) + AW'(cnt_reg)) : AW'(cnt_reg);

    assign cmd_pop      = issue && (cmd_rdata.err || final_beat);
    assign bank_release = issue && !cmd_rdata.err && final_beat;

    assign out_valid  = out_valid_reg;
    assign data_byte  = out_data_reg;
    assign byte_index = out_idx_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (issue)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= issue;
            out_valid_reg <= s1_valid_reg;
            if (issue && !cmd_rdata.err)
                cnt_reg <= final_beat ? '0 : cnt_reg + IW'(1);
        end
    end

    // Payload side of the two stages; qualified by the valid bits above.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            if (issue) begin
                s1_err_reg    <= cmd_rdata.err;
                s1_status_reg <= cmd_rdata.status;
                s1_idx_reg    <= cmd_rdata.err ? '0 : cnt_reg;
                s1_last_reg   <= cmd_rdata.err || final_beat;
            end
            out_data_reg   <= s1_err_reg ? 8'h00 : rd_data_reg;
            out_idx_reg    <= 3'(s1_idx_reg);
            out_status_reg <= s1_status_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

endmodule

FILE: hdl/rfid_frame_check_descramble_core.sv
// Top level of the frame checker and payload descrambler.
// Accepts one frame byte per cycle unless stalled; the CRC byte queues the frame's verdict.
// Results leave one beat per cycle when not stalled: eight per good frame, else one error beat.
// Input stalls only while both payload banks hold frames not yet drained or the verdict
// queue (two entries) is full; a frame is twelve bytes long by default.
// Asynchronous active-low reset resets control state and sets the header register to 0xAA.
`timescale 1ns / 1ps

module rfid_frame_check_descramble_core
    import rfc_pkg::*;
#(
    parameter int DATA_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic [2:0] byte_index,
    output logic [1:0] status,
    output logic       last
);

    localparam int AW = $clog2(NUM_BANKS * DATA_BYTES);
    localparam int IW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          cmd_push;
    logic          cmd_pop;
    logic          cmd_full;
    logic          cmd_empty;
    cmd_t          cmd_wdata;
    cmd_t          cmd_rdata;
    logic          bank_release;

    rfc_front #(
        .DATA_BYTES (DATA_BYTES),
        .AW         (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .frame_start  (frame_start),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .cmd_push     (cmd_push),
        .cmd_wdata    (cmd_wdata),
        .cmd_full     (cmd_full),
        .bank_release (bank_release)
    );

    rfc_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .full  (cmd_full),
        .empty (cmd_empty)
    );

    rfc_back #(
        .DATA_BYTES (DATA_BYTES),
        .AW         (AW),
        .IW         (IW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .cmd_rdata    (cmd_rdata),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .bank_release (bank_release),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .status       (status),
        .last         (last)
    );

`ifndef NO_ASSERTIONS
    a_err_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> last && (data_byte == 8'h00) && (byte_index == 3'd0))
        else $error("error beat is not a lone zero beat");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("verdict pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("verdict popped from an empty queue");

    a_release_is_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bank_release |-> cmd_pop && !cmd_rdata.err)
        else $error("payload bank released outside the last beat of a good frame");
`endif

endmodule
